@@ sv/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ sv/mpbm_pkg.sv @@
`default_nettype none

package mpbm_pkg;

    localparam int NEEDLE_W   = 64;
    localparam int LEN_W      = 4;
    localparam int LENS_W     = 16;
    localparam int NUM_SLOTS  = 4;
    localparam int IDX_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_3    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LENS = 3'd4;

    typedef struct packed {
        logic [NUM_SLOTS-1:0][NEEDLE_W-1:0] needle;
        logic [LENS_W-1:0]                  lengths;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } item_t;

    typedef struct packed {
        logic             valid;
        logic             found;
        logic [IDX_W-1:0] index;
    } result_t;

endpackage

`default_nettype wire

@@ sv/mpbm_cfg.sv @@
`default_nettype none

module mpbm_cfg
    import mpbm_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_NEEDLE_0:    cfg_next.needle[0] = cfg_wr_data;
                CFG_NEEDLE_1:    cfg_next.needle[1] = cfg_wr_data;
                CFG_NEEDLE_2:    cfg_next.needle[2] = cfg_wr_data;
                CFG_NEEDLE_3:    cfg_next.needle[3] = cfg_wr_data;
                CFG_NEEDLE_LENS: cfg_next.lengths   = cfg_wr_data[LENS_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ sv/mpbm_match.sv @@
`default_nettype none
`include "assert_macros.svh"

module mpbm_match
    import mpbm_pkg::*;
#(
    parameter int NEEDLES = 4,
    parameter int MAX_LEN = 8
) (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire cfg_t  cfg,
    input  wire logic  advance,
    input  wire item_t item,
    output result_t    result
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);

    logic [MAX_LEN-1:0][7:0] hist_reg;
    logic [MAX_LEN-1:0][7:0] hist_next;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;
    logic                    done_reg;

    // match_len[k][L-1]: newest L bytes equal the first L bytes of needle k
    logic [NEEDLES-1:0][MAX_LEN-1:0] match_len;
    logic [NEEDLES-1:0]              hit;
    logic [NEEDLES-1:0][LEN_W-1:0]   eff_len;
    logic                            any_hit;
    logic [IDX_W-1:0]                hit_idx;

    // hist index 0 is the oldest byte, MAX_LEN-1 the newest
    always_comb begin
        for (int i = 0; i < MAX_LEN - 1; i++) begin
            hist_next[i] = hist_reg[i+1];
        end
        hist_next[MAX_LEN-1] = item.data;
        cnt_next = (cnt_reg == CNT_W'(MAX_LEN)) ? cnt_reg : cnt_reg + 1'b1;
    end

    always_comb begin
        for (int k = 0; k < NEEDLES; k++) begin
            for (int l = 1; l <= MAX_LEN; l++) begin
                match_len[k][l-1] = 1'b1;
                for (int j = 0; j < l; j++) begin
                    if (cfg.needle[k][8*j +: 8] != hist_next[MAX_LEN-l+j]) begin
                        match_len[k][l-1] = 1'b0;
                    end
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < NEEDLES; k++) begin
            eff_len[k] = cfg.lengths[LEN_W*k +: LEN_W];
            if (eff_len[k] > LEN_W'(MAX_LEN)) begin
                eff_len[k] = LEN_W'(MAX_LEN);
            end
            hit[k] = 1'b0;
            for (int l = 1; l <= MAX_LEN; l++) begin
                if (eff_len[k] == LEN_W'(l) && LEN_W'(l) <= LEN_W'(cnt_next)) begin
                    hit[k] = match_len[k][l-1];
                end
            end
        end
    end

    // lowest index wins
    always_comb begin
        hit_idx = '0;
        for (int k = NEEDLES - 1; k >= 0; k--) begin
            if (hit[k]) begin
                hit_idx = IDX_W'(k);
            end
        end
        any_hit = |hit;
    end

    always_comb begin
        result.valid = !done_reg && (any_hit || item.last);
        result.found = any_hit;
        result.index = any_hit ? hit_idx : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg <= '0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (advance) begin
            if (item.last) begin
                hist_reg <= '0;
                cnt_reg  <= '0;
                done_reg <= 1'b0;
            end else begin
                hist_reg <= hist_next;
                cnt_reg  <= cnt_next;
                done_reg <= done_reg || any_hit;
            end
        end
    end

    `ASSERT_HOLDS(a_cnt_bounded, aclk, aresetn, cnt_reg <= CNT_W'(MAX_LEN), "count overflow")
    `ASSERT_HOLDS(a_hit_sets_done, aclk, aresetn, advance && any_hit && !item.last |=> done_reg, "match did not close search")
    `ASSERT_NEVER(a_no_result_after_done, aclk, aresetn, done_reg && result.valid, "result after match")

endmodule

`default_nettype wire

@@ sv/multi_pattern_byte_matcher.sv @@
// An accepted item sits in the input register; its registered result drives m_*.
// Throughput: one byte per cycle; the needle compares sit between the input
// register and the result register, so the only stall comes from m_ready.
// Reset (aresetn low, synchronous): needles, lengths, history, byte count and
// the match flag clear; both channels come up empty.
`default_nettype none
`include "assert_macros.svh"

module multi_pattern_byte_matcher
    import mpbm_pkg::*;
#(
    parameter int NEEDLES = 4,
    parameter int MAX_LEN = 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [7:0]            s_data_byte,
    input  wire logic                  s_is_last,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_found,
    output logic [IDX_W-1:0]           m_match_slot
);

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    logic    in_valid_next;
    logic    advance;
    logic    s_accept;
    result_t result;
    result_t out_reg;
    result_t out_next;

    mpbm_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    mpbm_match #(
        .NEEDLES (NEEDLES),
        .MAX_LEN (MAX_LEN)
    ) u_match (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .advance (advance),
        .item    (in_item_reg),
        .result  (result)
    );

    assign advance  = in_valid_reg && (!out_reg.valid || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_next = out_reg;
        if (advance) begin
            out_next = result;
        end else if (m_ready) begin
            out_next.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            out_reg      <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            out_reg      <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg.data <= s_data_byte;
            in_item_reg.last <= s_is_last;
        end
    end

    assign m_valid      = out_reg.valid;
    assign m_found      = out_reg.found;
    assign m_match_slot = out_reg.index;

    `ASSERT_HOLDS(a_no_bubble, aclk, aresetn, in_valid_reg && !out_reg.valid |-> s_ready, "input held while output empty")
    `ASSERT_HOLDS(a_miss_index_zero, aclk, aresetn, out_reg.valid && !out_reg.found |-> out_reg.index == '0, "index on no-match result")
    `ASSERT_HOLDS(a_held_when_stalled, aclk, aresetn, out_reg.valid && !m_ready |-> !advance, "result overwritten while stalled")

endmodule

`default_nettype wire
